[rtl/rsd_pkg.sv]
// rsd_pkg: shared constants, word types and controller/datapath command and status
// structs for the run-length sprite decoder
// no dependencies
`default_nettype none

package rsd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int BYTE_W      = 8;
    localparam int CFG_W       = 11;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 10;
    localparam int LIT_W       = 7;
    localparam int FILL_W      = 6;

    localparam int LIT_LIMIT   = 65;
    localparam int WIDTH_RESET = 64;
    localparam int FILL_BASE   = 256 - LIT_LIMIT;

    // position sum holds a column below MAX_WIDTH plus one skip byte
    localparam int SUM_W       = $clog2(MAX_WIDTH + 256);
    localparam int ROWCNT_W    = $clog2(MAX_ROWS);

    localparam logic [BYTE_W-1:0] SKIP_END  = 8'h80;
    localparam logic [BYTE_W-1:0] LIT_START = 8'hBF;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              frame_last;
    } in_word_t;

    typedef struct packed {
        logic [COL_W-1:0]  pixel_col;
        logic [ROW_W-1:0]  pixel_row;
        logic [BYTE_W-1:0] pixel_color;
        logic              run_last;
    } out_word_t;

    // position update: add byte, add one, or take off one row width
    typedef enum logic [1:0] {
        ADV_NONE,
        ADV_BYTE,
        ADV_ONE,
        ADV_STEP
    } adv_op_t;

    typedef struct packed {
        logic    capture;
        adv_op_t adv;
        logic    load_lit;
        logic    load_fill;
        logic    dec_lit;
        logic    dec_fill;
        logic    emit;
        logic    run_last;
        logic    clear;
    } dp_cmd_t;

    typedef struct packed {
        logic hdr_skip;
        logic hdr_lit;
        logic frame_last;
        logic lit_one;
        logic fill_one;
        logic col_ge_w;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/rsd_ctrl.sv]
// rsd_ctrl: sequencer for the sprite decoder, tracks run phase and drives the datapath
// depends on rsd_pkg
`default_nettype none

module rsd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rsd_pkg::dp_stat_t stat,
    output rsd_pkg::dp_cmd_t  cmd
);
    import rsd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_NORM
    } state_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_FILLCOLOR
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.adv    = ADV_NONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        state_next = ST_IDLE;
                        if (stat.frame_last)
                        begin
                            cmd.clear = 1'b1;
                        end
                        else if (stat.hdr_skip)
                        begin
                            cmd.adv    = ADV_BYTE;
                            state_next = ST_NORM;
                        end
                        else if (stat.hdr_lit)
                        begin
                            cmd.load_lit = 1'b1;
                            phase_next   = PH_LITERAL;
                        end
                        else
                        begin
                            cmd.load_fill = 1'b1;
                            phase_next    = PH_FILLCOLOR;
                        end
                    end

                    PH_LITERAL:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.run_last = 1'b1;
                            cmd.adv      = ADV_ONE;
                            cmd.dec_lit  = 1'b1;
                            if (stat.lit_one)
                                phase_next = PH_HEADER;
                            if (stat.frame_last)
                            begin
                                cmd.clear  = 1'b1;
                                phase_next = PH_HEADER;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                state_next = ST_NORM;
                            end
                        end
                    end

                    PH_FILLCOLOR:
                    begin
                        // first pixel goes out at the position as it stands
                        if (stat.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.run_last = stat.fill_one;
                            cmd.adv      = ADV_ONE;
                            cmd.dec_fill = 1'b1;
                            state_next   = ST_FILL;
                            if (stat.fill_one)
                            begin
                                phase_next = PH_HEADER;
                                if (stat.frame_last)
                                begin
                                    cmd.clear  = 1'b1;
                                    state_next = ST_IDLE;
                                end
                                else
                                begin
                                    state_next = ST_NORM;
                                end
                            end
                        end
                    end

                    default:
                    begin
                        phase_next = PH_HEADER;
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_FILL:
            begin
                // finish any row wrap before the next pixel
                if (stat.col_ge_w)
                begin
                    cmd.adv = ADV_STEP;
                end
                else if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.run_last = stat.fill_one;
                    cmd.adv      = ADV_ONE;
                    cmd.dec_fill = 1'b1;
                    if (stat.fill_one)
                    begin
                        phase_next = PH_HEADER;
                        if (stat.frame_last)
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_NORM;
                        end
                    end
                end
            end

            ST_NORM:
            begin
                if (stat.col_ge_w)
                    cmd.adv = ADV_STEP;
                else
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_HEADER;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("pixel issued while output register full");

    a_step_needs_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.adv == ADV_STEP) |-> stat.col_ge_w)
        else $error("row step without column overrun");

    a_fill_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (phase_reg == PH_FILLCOLOR))
        else $error("fill state outside fill phase");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

endmodule

`default_nettype wire

[rtl/rsd_datapath.sv]
// rsd_datapath: width register, position counters, run counters and output register
// depends on rsd_pkg
`default_nettype none

module rsd_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rsd_pkg::in_word_t         in_word,
    input  logic                      cfg_valid,
    input  logic [rsd_pkg::CFG_W-1:0] cfg_data,
    input  rsd_pkg::dp_cmd_t          cmd,
    output rsd_pkg::dp_stat_t         stat,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rsd_pkg::out_word_t        out_word
);
    import rsd_pkg::*;

    logic [SUM_W-1:0]    width_reg, width_cfg;
    logic [BYTE_W-1:0]   byte_reg;
    logic                last_reg;
    logic [SUM_W-1:0]    col_reg, col_next;
    logic [ROWCNT_W-1:0] row_reg, row_next, row_inc;
    logic [LIT_W-1:0]    lit_reg, lit_next, lit_len;
    logic [FILL_W-1:0]   fill_reg, fill_next, fill_len;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_word_reg;

    logic [SUM_W-1:0]    add_n;
    logic [SUM_W-1:0]    sum;
    logic                wrap;
    logic                out_free;

    // width of 0 acts as 1, anything above the maximum is clipped
    always_comb
    begin
        if (cfg_data == '0)
            width_cfg = SUM_W'(1);
        else if (32'(cfg_data) > 32'(MAX_WIDTH))
            width_cfg = SUM_W'(MAX_WIDTH);
        else
            width_cfg = SUM_W'(cfg_data);
    end

    always_comb
    begin
        case (cmd.adv)
            ADV_BYTE: add_n = SUM_W'(byte_reg);
            ADV_ONE:  add_n = SUM_W'(1);
            default:  add_n = '0;
        endcase
        sum     = col_reg + add_n;
        wrap    = (cmd.adv != ADV_NONE) && (sum >= width_reg);
        row_inc = (row_reg == ROWCNT_W'(MAX_ROWS - 1)) ? '0 : row_reg + ROWCNT_W'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (cmd.clear)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.adv != ADV_NONE)
        begin
            col_next = wrap ? (sum - width_reg) : sum;
            if (wrap)
                row_next = row_inc;
        end
    end

    assign lit_len  = LIT_W'(9'd256 - {1'b0, byte_reg});
    assign fill_len = FILL_W'(BYTE_W'(FILL_BASE) - byte_reg);

    always_comb
    begin
        lit_next  = lit_reg;
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            lit_next  = '0;
            fill_next = '0;
        end
        else
        begin
            if (cmd.load_lit)
                lit_next = lit_len;
            else if (cmd.dec_lit && lit_reg != '0)
                lit_next = lit_reg - LIT_W'(1);
            if (cmd.load_fill)
                fill_next = fill_len;
            else if (cmd.dec_fill && fill_reg != '0)
                fill_next = fill_reg - FILL_W'(1);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SUM_W'(WIDTH_RESET);
            col_reg       <= '0;
            row_reg       <= '0;
            lit_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                width_reg <= width_cfg;
            col_reg       <= col_next;
            row_reg       <= row_next;
            lit_reg       <= lit_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= in_word.stream_byte;
            last_reg <= in_word.frame_last;
        end
        if (cmd.emit)
        begin
            out_word_reg.pixel_col   <= COL_W'(col_reg);
            out_word_reg.pixel_row   <= ROW_W'(row_reg);
            out_word_reg.pixel_color <= byte_reg;
            out_word_reg.run_last    <= cmd.run_last;
        end
    end

    assign stat.hdr_skip   = (byte_reg < SKIP_END);
    assign stat.hdr_lit    = (byte_reg >= LIT_START);
    assign stat.frame_last = last_reg;
    assign stat.lit_one    = (lit_reg <= LIT_W'(1));
    assign stat.fill_one   = (fill_reg == FILL_W'(1));
    assign stat.col_ge_w   = (col_reg >= width_reg);
    assign stat.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_width_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> (width_reg != '0 && width_reg <= SUM_W'(MAX_WIDTH)))
        else $error("sprite width register out of range");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted pixel not presented");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_word_reg)))
        else $error("output word changed while stalled");

endmodule

`default_nettype wire

[rtl/rle_sprite_decode.sv]
// rle_sprite_decode: top level of the run-length sprite decoder
// a header byte is captured in idle and decoded in execute; literal and skip bytes go
// on to normalise, which steps once per extra row a skip crosses; a fill colour emits
// in execute and the fill state, rows wrapping in the pixel cycle; frame-ending bytes
// skip normalise; one fill pixel per cycle while output is free, via one position adder
// async active-low reset: width 64, position at the origin, expecting a run header
`default_nettype none

module rle_sprite_decode (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rsd_pkg::in_word_t         in_word,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rsd_pkg::out_word_t        out_word,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rsd_pkg::CFG_W-1:0] cfg_data
);
    import rsd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // width register takes a write in any cycle
    assign cfg_ready = 1'b1;

    rsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rsd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

[test/tb_rle_sprite_decode.sv]
// tb_rle_sprite_decode: self-checking testbench for the run-length sprite decoder
// a table of directed words, then randomised runs over several sprite widths
// depends on rsd_pkg and rle_sprite_decode
module tb_rle_sprite_decode;
    timeunit 1ns;
    timeprecision 1ps;

    import rsd_pkg::*;

    typedef enum {EXPECT_HEADER, IN_LITERAL, FILL_COLOUR} dec_phase_t;
    typedef enum {RUN_SKIP, RUN_LITERAL, RUN_FILL, RUN_NOISE} run_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              frame_last;
        logic              typed;
        out_word_t         px;
    } stim_row_t;

    localparam out_word_t NONE = '0;
    localparam int N_DIRECTED = 25;
    localparam int N_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 12;
    // longest skip with width 1 and a column near the top steps through ~1150 rows
    localparam int SETTLE_CYCLES = 1500;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'hAB, 1'b0, 1'b1, '{10'd0, 10'd0, 8'hAB, 1'b1}},
        '{8'h7F, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h80, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'hBE, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b1, '{10'd63, 10'd2, 8'h00, 1'b1}},
        '{8'hBF, 1'b0, 1'b0, NONE},
        '{8'h55, 1'b0, 1'b0, NONE},
        '{8'hAA, 1'b0, 1'b0, NONE},
        '{8'h01, 1'b0, 1'b0, NONE},
        '{8'h12, 1'b1, 1'b1, '{10'd3, 10'd3, 8'h12, 1'b1}},
        '{8'hC0, 1'b1, 1'b0, NONE},
        '{8'h81, 1'b0, 1'b0, NONE},
        '{8'h3C, 1'b1, 1'b0, NONE},
        '{8'hFE, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b1, '{10'd0, 10'd0, 8'h00, 1'b1}},
        '{8'hFF, 1'b0, 1'b1, '{10'd1, 10'd0, 8'hFF, 1'b1}},
        '{8'h7F, 1'b1, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'h80, 1'b0, 1'b1, '{10'd0, 10'd0, 8'h80, 1'b1}},
        '{8'h3E, 1'b0, 1'b0, NONE},
        '{8'h82, 1'b0, 1'b0, NONE},
        '{8'h5A, 1'b0, 1'b0, NONE}
    };

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_word_t         in_word;
    logic             out_valid;
    logic             out_ready;
    out_word_t        out_word;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // decoder mirror
    logic [CFG_W-1:0] width_reg;
    dec_phase_t       dec_phase;
    int               lit_left;
    int               fill_len;
    int               cur_col;
    int               cur_row;

    out_word_t pixel_q [$];
    int        errors;
    bit        tx_calm;
    bit        rx_calm;

    rle_sprite_decode DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void clear_position();
        dec_phase = EXPECT_HEADER;
        lit_left  = 0;
        fill_len  = 0;
        cur_col   = 0;
        cur_row   = 0;
    endfunction

    function automatic void step_position(int n);
        int w;
        int total;
        w = int'(width_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        total   = cur_col + n;
        cur_row = (cur_row + total / w) % MAX_ROWS;
        cur_col = total % w;
    endfunction

    function automatic void queue_pixel(logic [BYTE_W-1:0] colour, logic last);
        out_word_t p;
        p.pixel_col   = cur_col[COL_W-1:0];
        p.pixel_row   = cur_row[ROW_W-1:0];
        p.pixel_color = colour;
        p.run_last    = last;
        pixel_q.push_back(p);
    endfunction

    function automatic void decode_byte(in_word_t w);
        int len;
        int k;
        case (dec_phase)
            EXPECT_HEADER:
            begin
                if (w.stream_byte < SKIP_END)
                    step_position(int'(w.stream_byte));
                else
                begin
                    len = 256 - int'(w.stream_byte);
                    if (len > LIT_LIMIT)
                    begin
                        fill_len  = (len - LIT_LIMIT) % 64;
                        dec_phase = FILL_COLOUR;
                    end
                    else
                    begin
                        lit_left  = len;
                        dec_phase = IN_LITERAL;
                    end
                end
            end
            IN_LITERAL:
            begin
                queue_pixel(w.stream_byte, 1'b1);
                step_position(1);
                if (lit_left > 0)
                    lit_left--;
                if (lit_left == 0)
                    dec_phase = EXPECT_HEADER;
            end
            default:
            begin
                for (k = 0; k < fill_len; k++)
                begin
                    queue_pixel(w.stream_byte, k + 1 == fill_len);
                    step_position(1);
                end
                fill_len  = 0;
                dec_phase = EXPECT_HEADER;
            end
        endcase
        if (w.frame_last)
            clear_position();
    endfunction

    // typed rows replace whatever the mirror predicts with the hand-written pixel
    task automatic send_word(input logic [BYTE_W-1:0] b, input logic last,
                             input logic typed, input out_word_t px);
        int before_n;
        in_word  <= '{stream_byte: b, frame_last: last};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        before_n = pixel_q.size();
        decode_byte('{stream_byte: b, frame_last: last});
        if (typed)
        begin
            while (pixel_q.size() > before_n)
                void'(pixel_q.pop_back());
            pixel_q.push_back(px);
        end
        if (!tx_calm && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    task automatic write_width(input logic [CFG_W-1:0] v);
        in_valid <= 1'b0;
        wait (pixel_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        width_reg = v;
    endtask

    function automatic bit roll_last(int pct);
        return pct > 0 && $urandom_range(0, 99) < pct;
    endfunction

    // one well-formed run with random content, or a stray word now and then
    task automatic send_run(input int skip_pct, input int last_pct, inout int cnt);
        run_kind_t kind;
        int        n;
        int        k;
        int        r;
        bit        last;
        r = $urandom_range(0, 99);
        if (r < 10)
            kind = RUN_NOISE;
        else if (r < 10 + skip_pct)
            kind = RUN_SKIP;
        else if (r < 10 + skip_pct + (90 - skip_pct) / 2)
            kind = RUN_LITERAL;
        else
            kind = RUN_FILL;
        last = roll_last(last_pct);
        case (kind)
            RUN_NOISE:
            begin
                send_word(BYTE_W'($urandom_range(0, 255)), last, 1'b0, NONE);
                cnt++;
            end
            RUN_SKIP:
            begin
                send_word(BYTE_W'($urandom_range(0, SKIP_END - 1)), last, 1'b0, NONE);
                cnt++;
            end
            RUN_LITERAL:
            begin
                n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, LIT_LIMIT);
                send_word(BYTE_W'(256 - n), last, 1'b0, NONE);
                cnt++;
                for (k = 0; k < n && !last; k++)
                begin
                    last = roll_last(last_pct);
                    send_word(BYTE_W'($urandom_range(0, 255)), last, 1'b0, NONE);
                    cnt++;
                end
            end
            default:
            begin
                n = $urandom_range(1, 63);
                send_word(BYTE_W'(FILL_BASE - n), last, 1'b0, NONE);
                cnt++;
                if (!last)
                begin
                    send_word(BYTE_W'($urandom_range(0, 255)), roll_last(last_pct),
                              1'b0, NONE);
                    cnt++;
                end
            end
        endcase
    endtask

    // receiver: bursts of stalls alternating with stretches of steady ready
    initial
    begin
        int hold;
        hold      = 0;
        rx_calm   = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    hold = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected pixel: expected none, got col %0d row %0d",
                         $time, out_word.pixel_col, out_word.pixel_row,
                         " colour %02h last %0b", out_word.pixel_color, out_word.run_last);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (out_word.pixel_col !== want.pixel_col
                    || out_word.pixel_row !== want.pixel_row
                    || out_word.pixel_color !== want.pixel_color
                    || out_word.run_last !== want.run_last)
                begin
                    errors++;
                    $display("%0t pixel mismatch: expected col %0d row %0d colour %02h",
                             $time, want.pixel_col, want.pixel_row, want.pixel_color,
                             " last %0b, got col %0d row %0d colour %02h last %0b",
                             want.run_last, out_word.pixel_col, out_word.pixel_row,
                             out_word.pixel_color, out_word.run_last);
                end
            end
        end
    end

    initial
    begin
        logic [CFG_W-1:0] phase_width [N_PHASES];
        int p;
        int i;
        int cnt;
        bit paused;
        errors    = 0;
        tx_calm   = 1'b0;
        paused    = 1'b0;
        width_reg = CFG_W'(WIDTH_RESET);
        clear_position();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        // zero and overlarge widths clamp; first two phases walk rows past the wrap
        phase_width = '{11'd0, 11'd1, 11'd2047, 11'd1024, 11'd3, 11'd200, 11'd64, 11'd1};
        phase_width[N_PHASES-1] = CFG_W'($urandom_range(1, MAX_WIDTH));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED[i].stream_byte, DIRECTED[i].frame_last,
                      DIRECTED[i].typed, DIRECTED[i].px);

        for (p = 0; p < N_PHASES; p++)
        begin
            write_width(phase_width[p]);
            tx_calm = (p % 3 == 2);
            cnt = 0;
            while (cnt < ITEMS_PER_PHASE)
            begin
                send_run(p < 2 ? 60 : 30, p < 2 ? 0 : 4, cnt);
                if (p == 3 && !paused && cnt >= 8)
                begin
                    // hold the sender until the decoder has drained
                    paused = 1'b1;
                    in_valid <= 1'b0;
                    wait (pixel_q.size() == 0);
                    @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        wait (pixel_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
